// ----- design/id_free_list_allocator_macros.svh -----
// Assertion macros shared by the number allocator modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef ID_FREE_LIST_ALLOCATOR_MACROS_SVH
`define ID_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IDFL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("idfl: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IDFL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("idfl: next-cycle check failed");

`endif

// ----- design/idfl_pkg.sv -----
// Types and constants of the number allocator.
// Depends on nothing; used by every other file of the block but the macros.
package idfl_pkg;

  localparam int MAX_IDS = 1024;
  localparam int IDX_W   = $clog2(MAX_IDS);
  localparam int CNT_W   = $clog2(MAX_IDS + 1);
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  localparam logic [CNT_W-1:0] SIZE_MAX = CNT_W'(MAX_IDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_IDS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE
  } state_t;

  typedef struct packed {
    logic init;
    logic clear_step;
    logic capture;
    logic resolve;
  } idfl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } idfl_status_t;

endpackage

// ----- design/idfl_if.sv -----
// Channel interfaces of the number allocator: request, result, size write.
// Depends on idfl_pkg.
interface idfl_req_if import idfl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  number;

  modport source (output valid, output kind, output number, input ready);
  modport sink   (input valid, input kind, input number, output ready);
endinterface

interface idfl_res_if import idfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] granted_number;
  logic             none_free;
  logic             is_available;

  modport source (output valid, output granted_number, output none_free,
                  output is_available, input ready);
  modport sink   (input valid, input granted_number, input none_free,
                  input is_available, output ready);
endinterface

interface idfl_cfg_if import idfl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] numbers_in_use;

  modport source (output valid, output numbers_in_use, input ready);
  modport sink   (input valid, input numbers_in_use, output ready);
endinterface

// ----- design/idfl_ctrl.sv -----
// Controller of the number allocator: clear sweep, request capture, resolve.
// Depends on idfl_pkg and id_free_list_allocator_macros.svh.
`include "id_free_list_allocator_macros.svh"

module idfl_ctrl import idfl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         cfg_write,
  input  idfl_status_t status,
  output logic         req_ready,
  output idfl_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
    if (cfg_write) state_next = ST_CLEAR;
  end

  always_comb begin
    req_ready      = 1'b0;
    cmd.init       = cfg_write;
    cmd.clear_step = 1'b0;
    cmd.capture    = 1'b0;
    cmd.resolve    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      ST_RESOLVE: begin
        cmd.resolve = status.out_free;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  `IDFL_ASSERT_NXT(a_no_back_to_back_capture, clk, rst, cmd.capture, !cmd.capture)
  `IDFL_ASSERT_NXT(a_cfg_restarts_clear, clk, rst, cfg_write, state == ST_CLEAR)
  `IDFL_ASSERT_IMP(a_no_capture_in_clear, clk, rst, cmd.clear_step, !req_ready)

endmodule

// ----- design/idfl_dp.sv -----
// Datapath of the number allocator: free-list stack, in-use map, pointer,
// size register and result register. Depends on idfl_pkg and the macros.
`include "id_free_list_allocator_macros.svh"

module idfl_dp import idfl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  idfl_cmd_t         cmd,
  output idfl_status_t      status,
  input  logic [CNT_W-1:0]  cfg_size,
  input  logic [KIND_W-1:0] req_kind,
  input  logic [IDX_W-1:0]  req_number,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [IDX_W-1:0]  out_granted,
  output logic              out_none,
  output logic              out_avail
);

  logic [IDX_W-1:0] stack_mem [MAX_IDS];
  logic             map_mem   [MAX_IDS];

  logic [CNT_W-1:0]  size;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  touched;
  logic [CNT_W-1:0]  touched_next;
  logic [IDX_W-1:0]  clr_addr;
  logic [KIND_W-1:0] kind;
  logic [IDX_W-1:0]  number;
  logic [IDX_W-1:0]  stack_rd;
  logic              map_rd;

  logic [IDX_W-1:0] top_val;
  logic [CNT_W-1:0] count_dec;
  logic             num_in_range;
  logic             stack_we;
  logic             map_we;
  logic [IDX_W-1:0] map_waddr;
  logic             map_wdata;
  logic [IDX_W-1:0] granted_next;
  logic             none_next;
  logic             avail_next;

  assign status.clear_last = (clr_addr == LAST_IDX);
  assign status.out_free   = !out_valid || out_ready;

  assign top_val      = (count >= touched) ? count[IDX_W-1:0] : stack_rd;
  assign count_dec    = count - CNT_W'(1);
  assign num_in_range = ({1'b0, number} < size);

  always_comb begin
    count_next   = count;
    touched_next = touched;
    stack_we     = 1'b0;
    map_we       = 1'b0;
    map_waddr    = number;
    map_wdata    = 1'b0;
    granted_next = '0;
    none_next    = 1'b0;
    avail_next   = 1'b0;
    if (cmd.clear_step) begin
      map_we    = 1'b1;
      map_waddr = clr_addr;
    end else if (cmd.resolve) begin
      unique case (kind)
        KIND_ALLOC: begin
          if (count >= size) begin
            none_next = 1'b1;
          end else begin
            granted_next = top_val;
            count_next   = count + CNT_W'(1);
            map_we       = 1'b1;
            map_waddr    = top_val;
            map_wdata    = 1'b1;
          end
        end
        KIND_CHECK: begin
          avail_next = num_in_range && !map_rd;
        end
        KIND_RELEASE: begin
          if (num_in_range && map_rd && (count != '0)) begin
            count_next = count_dec;
            stack_we   = 1'b1;
            map_we     = 1'b1;
            if (count > touched) touched_next = count;
          end
        end
        default: begin
          granted_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[count_dec[IDX_W-1:0]] <= number;
    if (cmd.capture) stack_rd <= stack_mem[count[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (cmd.capture) map_rd <= map_mem[req_number];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind   <= req_kind;
      number <= req_number;
    end
    if (cmd.resolve) begin
      out_granted <= granted_next;
      out_none    <= none_next;
      out_avail   <= avail_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= SIZE_MAX;
      count     <= '0;
      touched   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.init) begin
        size     <= (cfg_size > SIZE_MAX) ? SIZE_MAX : cfg_size;
        count    <= '0;
        touched  <= '0;
        clr_addr <= '0;
      end else begin
        count   <= count_next;
        touched <= touched_next;
        if (cmd.clear_step) clr_addr <= clr_addr + IDX_W'(1);
      end
      if (cmd.resolve) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `IDFL_ASSERT_IMP(a_count_within_size, clk, rst, 1'b1, count <= size)
  `IDFL_ASSERT_IMP(a_result_not_overwritten, clk, rst, cmd.resolve, !out_valid || out_ready)
  `IDFL_ASSERT_NXT(a_alloc_advances, clk, rst, cmd.resolve && !cmd.init && (kind == KIND_ALLOC) && (count < size), count == $past(count) + CNT_W'(1))

endmodule

// ----- design/id_free_list_allocator.sv -----
// Channel   | Dir | Payload
// cfg       | in  | numbers_in_use (11 bits); always ready
// req       | in  | kind (2 bits), number (10 bits)
// res       | out | granted_number (10 bits), none_free, is_available
//
// A request is captured in the idle state, which reads the stack top and
// the in-use bit from single-port memories; resolve loads the result.
// The result register frees the input side once the result is loaded.
// After reset and after every size write the in-use map is cleared, one
// entry a cycle, over all of its entries while req is not ready.
// A stalled result holds the block in its resolve state.
module id_free_list_allocator import idfl_pkg::*; (
  input logic       clk,
  input logic       rst,
  idfl_cfg_if.sink  cfg,
  idfl_req_if.sink  req,
  idfl_res_if.source res
);

  idfl_cmd_t    cmd;
  idfl_status_t status;
  logic         req_ready;

  assign cfg.ready = 1'b1;
  assign req.ready = req_ready;

  idfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .cfg_write (cfg.valid),
    .status    (status),
    .req_ready (req_ready),
    .cmd       (cmd)
  );

  idfl_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_size    (cfg.numbers_in_use),
    .req_kind    (req.kind),
    .req_number  (req.number),
    .out_ready   (res.ready),
    .out_valid   (res.valid),
    .out_granted (res.granted_number),
    .out_none    (res.none_free),
    .out_avail   (res.is_available)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for id_free_list_allocator: directed table, then random request phases.
// Depends on idfl_pkg and the idfl_req_if, idfl_res_if and idfl_cfg_if interfaces.
module tb_top import idfl_pkg::*; ();

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 125;
  localparam int DIR_N = 26;

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    logic             none;
    logic             avail;
  } outcome_t;

  typedef struct packed {
    bit               wr;
    logic [CNT_W-1:0] size;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0] num;
    bit               known;
    outcome_t         res;
  } dir_row_t;

  // wr, size, kind, number, known, {granted, none_free, is_available}
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{0, 0,    KIND_CHECK,   0,    1, '{0, 0, 1}},
    '{0, 0,    KIND_CHECK,   1023, 1, '{0, 0, 1}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{1, 0, 0}},
    '{0, 0,    KIND_CHECK,   0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_RELEASE, 1,    1, '{0, 0, 0}},
    '{0, 0,    KIND_RELEASE, 1,    1, '{0, 0, 0}},
    '{0, 0,    KIND_NOP,     1023, 1, '{0, 0, 0}},
    '{0, 0,    KIND_ALLOC,   1023, 0, '{0, 0, 0}},
    '{0, 0,    KIND_RELEASE, 1023, 1, '{0, 0, 0}},
    '{1, 0,    KIND_ALLOC,   0,    1, '{0, 1, 0}},
    '{0, 0,    KIND_CHECK,   0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_RELEASE, 0,    1, '{0, 0, 0}},
    '{1, 1,    KIND_ALLOC,   0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{0, 1, 0}},
    '{0, 0,    KIND_CHECK,   1,    1, '{0, 0, 0}},
    '{0, 0,    KIND_RELEASE, 0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_CHECK,   0,    1, '{0, 0, 1}},
    '{1, 2047, KIND_CHECK,   1023, 1, '{0, 0, 1}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{0, 0, 0}},
    '{1, 3,    KIND_ALLOC,   0,    1, '{0, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{1, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{2, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    1, '{0, 1, 0}},
    '{0, 0,    KIND_RELEASE, 1,    1, '{0, 0, 0}},
    '{0, 0,    KIND_ALLOC,   0,    0, '{0, 0, 0}}
  };

  logic clk;
  logic rst;

  idfl_req_if req ();
  idfl_res_if res ();
  idfl_cfg_if cfg ();

  id_free_list_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .res (res)
  );

  logic [IDX_W-1:0] pool_stack [MAX_IDS];
  bit               taken_map [MAX_IDS];
  logic [CNT_W-1:0] top_ptr;
  logic [CNT_W-1:0] pool_size;
  int               held_q [$];

  outcome_t pending_results [$];
  outcome_t want;

  int  errors = 0;
  int  cycle_count;
  int  hold_left = 0;
  bit  calm = 1'b0;
  int  n_granted = 0;
  int  n_exhausted = 0;
  int  n_free_checks = 0;
  int  n_freed = 0;
  int  n_size_writes = 0;
  int  n_requests = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void set_pool(logic [CNT_W-1:0] v);
    pool_size = (v > SIZE_MAX) ? SIZE_MAX : v;
    for (int i = 0; i < MAX_IDS; i++) begin
      pool_stack[i] = IDX_W'(i);
      taken_map[i] = 1'b0;
    end
    top_ptr = '0;
    held_q.delete();
  endfunction

  function automatic outcome_t apply_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] n);
    outcome_t o;
    logic [IDX_W-1:0] g;
    o = '0;
    case (k)
      KIND_ALLOC: begin
        if (top_ptr >= pool_size) begin
          o.none = 1'b1;
          n_exhausted++;
        end else begin
          g = pool_stack[top_ptr[IDX_W-1:0]];
          top_ptr = top_ptr + 1'b1;
          taken_map[g] = 1'b1;
          o.granted = g;
          held_q.insert(held_q.size(), int'(g));
          n_granted++;
        end
      end
      KIND_CHECK: begin
        o.avail = (CNT_W'(n) < pool_size) && !taken_map[n];
        if (o.avail) n_free_checks++;
      end
      KIND_RELEASE: begin
        if (CNT_W'(n) < pool_size && taken_map[n] && top_ptr != 0) begin
          taken_map[n] = 1'b0;
          top_ptr = top_ptr - 1'b1;
          pool_stack[top_ptr[IDX_W-1:0]] = n;
          n_freed++;
          for (int i = 0; i < held_q.size(); i++) begin
            if (held_q[i] == int'(n)) begin
              held_q.delete(i);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic send_req(logic [KIND_W-1:0] k, logic [IDX_W-1:0] n, bit typed, outcome_t fixed);
    int gap;
    outcome_t pred;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.kind   <= k;
    req.number <= n;
    do @(posedge clk); while (!req.ready);
    pred = apply_request(k, n);
    pending_results.insert(pending_results.size(), typed ? fixed : pred);
    n_requests++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(logic [CNT_W-1:0] v);
    drain();
    cfg.valid          <= 1'b1;
    cfg.numbers_in_use <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    set_pool(v);
    n_size_writes++;
  endtask

  task automatic random_request();
    int r;
    int hi;
    logic [KIND_W-1:0] k;
    logic [IDX_W-1:0] n;
    r = $urandom_range(0, 99);
    hi = (int'(pool_size) + 2 > MAX_IDS - 1) ? MAX_IDS - 1 : int'(pool_size) + 2;
    n = IDX_W'($urandom_range(0, MAX_IDS - 1));
    if (r < 40) begin
      k = KIND_ALLOC;
    end else if (r < 60) begin
      k = KIND_CHECK;
      if ($urandom_range(0, 99) < 70) n = IDX_W'($urandom_range(0, hi));
    end else if (r < 88) begin
      k = KIND_RELEASE;
      if (held_q.size() != 0) n = IDX_W'(held_q[$urandom_range(0, held_q.size() - 1)]);
    end else if (r < 95) begin
      k = KIND_RELEASE;
    end else begin
      k = KIND_NOP;
    end
    send_req(k, n, 1'b0, '0);
  endtask

  function automatic logic [CNT_W-1:0] phase_size(int p);
    case (p)
      0: return SIZE_MAX;
      1: return '1;
      2: return CNT_W'($urandom_range(MAX_IDS + 1, 2046));
      3: return CNT_W'(1);
      4: return CNT_W'(2);
      default: return CNT_W'($urandom_range(3, 40));
    endcase
  endfunction

  always @(posedge clk) begin
    if ($urandom_range(0, 249) == 0) calm <= ~calm;
  end

  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 25) begin
      res.ready <= 1'b0;
      hold_left <= pick_gap();
    end else begin
      res.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result granted=%0d none_free=%0b is_available=%0b",
                 $time, res.granted_number, res.none_free, res.is_available);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (res.granted_number !== want.granted) begin
          $display("%0t: granted_number expected %0d got %0d",
                   $time, want.granted, res.granted_number);
          errors++;
        end
        if (res.none_free !== want.none) begin
          $display("%0t: none_free expected %0b got %0b", $time, want.none, res.none_free);
          errors++;
        end
        if (res.is_available !== want.avail) begin
          $display("%0t: is_available expected %0b got %0b",
                   $time, want.avail, res.is_available);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: cycle limit reached with %0d results outstanding",
             $time, pending_results.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    req.valid          <= 1'b0;
    req.kind           <= KIND_ALLOC;
    req.number         <= '0;
    cfg.valid          <= 1'b0;
    cfg.numbers_in_use <= '0;
    set_pool(SIZE_MAX);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].wr) write_size(DIR_TAB[i].size);
      send_req(DIR_TAB[i].kind, DIR_TAB[i].num, DIR_TAB[i].known, DIR_TAB[i].res);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_size(phase_size(p));
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        // hold the sender until every outstanding request has answered
        if (j == PHASE_ITEMS / 2) drain();
        random_request();
      end
    end

    drain();
    repeat (8) @(posedge clk);

    $display("Covered %0d requests over %0d size writes: %0d grants, %0d exhausted allocates,",
             n_requests, n_size_writes, n_granted, n_exhausted);
    $display("%0d free checks answered yes, %0d numbers released; %0d mismatches",
             n_free_checks, n_freed, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/idfl_pkg.sv
design/idfl_if.sv
design/idfl_ctrl.sv
design/idfl_dp.sv
design/id_free_list_allocator.sv
tb/sv/tb_top.sv
